### rtl/core/sssd_pkg.sv
package sssd_pkg;

  localparam int NIBBLE_W   = 4;
  localparam int SLOT_COUNT = 4;
  localparam int POS_W      = 2;
  localparam int PACKED_W   = 16;
  localparam int VALUE_W    = 16;
  localparam int PORT_W     = 8;

  // Value modulo 10000 fits in 14 bits; quotients of it by 10, 100 and 1000.
  localparam int REM_W   = 14;
  localparam int Q10_W   = 10;
  localparam int Q100_W  = 7;
  localparam int Q1000_W = 4;
  localparam int PROD_W  = 30;

  // Reciprocal constants, exact for dividends below 10000.
  localparam logic [15:0] RECIP_10   = 16'd52429;
  localparam int          SHIFT_10   = 19;
  localparam logic [15:0] RECIP_100  = 16'd5243;
  localparam int          SHIFT_100  = 19;
  localparam logic [15:0] RECIP_1000 = 16'd8389;
  localparam int          SHIFT_1000 = 23;

  localparam logic [VALUE_W-1:0] TEN_THOUSAND = 16'd10000;

  typedef enum logic [1:0] {
    REQ_SET_DIGITS = 2'd0,
    REQ_SET_VALUE  = 2'd1,
    REQ_TICK       = 2'd2,
    REQ_NONE       = 2'd3
  } req_t;

  typedef struct packed {
    req_t                kind;
    logic [PACKED_W-1:0] digits;
    logic [REM_W-1:0]    rem;
  } rem_item_t;

  typedef struct packed {
    req_t                kind;
    logic [PACKED_W-1:0] digits;
    logic [REM_W-1:0]    rem;
    logic [Q10_W-1:0]    q10;
    logic [Q100_W-1:0]   q100;
    logic [Q1000_W-1:0]  q1000;
  } split_t;

endpackage

### rtl/core/sssd_ifs.sv
interface sssd_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic [sssd_pkg::PACKED_W-1:0]   digits_packed;
  logic [sssd_pkg::VALUE_W-1:0]    binary_value;

  modport source (output valid, output req_type, output digits_packed,
                  output binary_value, input ready);
  modport sink   (input valid, input req_type, input digits_packed,
                  input binary_value, output ready);
endinterface

interface sssd_out_if;
  logic                          valid;
  logic                          ready;
  logic [sssd_pkg::PORT_W-1:0]   port_byte;

  modport source (output valid, output port_byte, input ready);
  modport sink   (input valid, input port_byte, output ready);
endinterface

### rtl/core/sssd_split.sv
module sssd_split (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [sssd_pkg::PACKED_W-1:0] in_digits,
  input  logic [sssd_pkg::VALUE_W-1:0]  in_value,
  output logic                          split_valid,
  input  logic                          split_ready,
  output sssd_pkg::split_t              split
);

  logic                          s0_valid_r;
  sssd_pkg::req_t                s0_kind_r;
  logic [sssd_pkg::PACKED_W-1:0] s0_digits_r;
  logic [sssd_pkg::VALUE_W-1:0]  s0_value_r;

  logic                          s1_valid_r;
  sssd_pkg::rem_item_t           s1_item_r;
  logic                          s2_valid_r;
  sssd_pkg::split_t              s2_item_r;

  logic                          s0_ready;
  logic                          s1_ready;
  logic                          s2_ready;
  logic [2:0]                    tt;
  logic [sssd_pkg::VALUE_W-1:0]  tt_sub;
  sssd_pkg::rem_item_t           s1_item_nxt;
  logic [sssd_pkg::PROD_W-1:0]   p10;
  logic [sssd_pkg::PROD_W-1:0]   p100;
  logic [sssd_pkg::PROD_W-1:0]   p1000;
  sssd_pkg::split_t              s2_item_nxt;

  assign s2_ready = !s2_valid_r || split_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s0_ready = !s0_valid_r || s1_ready;
  assign in_ready = s0_ready;

  // Ten-thousands count by compare, then drop it from the value.
  always_comb begin
    priority if (s0_value_r >= 16'd60000) tt = 3'd6;
    else if (s0_value_r >= 16'd50000) tt = 3'd5;
    else if (s0_value_r >= 16'd40000) tt = 3'd4;
    else if (s0_value_r >= 16'd30000) tt = 3'd3;
    else if (s0_value_r >= 16'd20000) tt = 3'd2;
    else if (s0_value_r >= 16'd10000) tt = 3'd1;
    else tt = 3'd0;
    tt_sub             = sssd_pkg::VALUE_W'(tt) * sssd_pkg::TEN_THOUSAND;
    s1_item_nxt.kind   = s0_kind_r;
    s1_item_nxt.digits = s0_digits_r;
    s1_item_nxt.rem    = sssd_pkg::REM_W'(s0_value_r - tt_sub);
  end

  // Quotients of the remainder by 10, 100 and 1000 through reciprocals.
  always_comb begin
    p10   = sssd_pkg::PROD_W'(s1_item_r.rem) * sssd_pkg::PROD_W'(sssd_pkg::RECIP_10);
    p100  = sssd_pkg::PROD_W'(s1_item_r.rem) * sssd_pkg::PROD_W'(sssd_pkg::RECIP_100);
    p1000 = sssd_pkg::PROD_W'(s1_item_r.rem) * sssd_pkg::PROD_W'(sssd_pkg::RECIP_1000);
    s2_item_nxt.kind   = s1_item_r.kind;
    s2_item_nxt.digits = s1_item_r.digits;
    s2_item_nxt.rem    = s1_item_r.rem;
    s2_item_nxt.q10    = sssd_pkg::Q10_W'(p10 >> sssd_pkg::SHIFT_10);
    s2_item_nxt.q100   = sssd_pkg::Q100_W'(p100 >> sssd_pkg::SHIFT_100);
    s2_item_nxt.q1000  = sssd_pkg::Q1000_W'(p1000 >> sssd_pkg::SHIFT_1000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s0_ready) s0_valid_r <= in_valid;
      if (s1_ready) s1_valid_r <= s0_valid_r;
      if (s2_ready) s2_valid_r <= s1_valid_r;
    end
    if (s0_ready && in_valid) begin
      s0_kind_r   <= sssd_pkg::req_t'(in_kind);
      s0_digits_r <= in_digits;
      s0_value_r  <= in_value;
    end
    if (s1_ready && s0_valid_r) s1_item_r <= s1_item_nxt;
    if (s2_ready && s1_valid_r) s2_item_r <= s2_item_nxt;
  end

  assign split_valid = s2_valid_r;
  assign split       = s2_item_r;

endmodule

### rtl/core/sssd_scan.sv
module sssd_scan #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        split_valid,
  output logic                        split_ready,
  input  sssd_pkg::split_t            split,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sssd_pkg::PORT_W-1:0] port_byte
);

  localparam int NW = sssd_pkg::NIBBLE_W;
  localparam int SC = sssd_pkg::SLOT_COUNT;

  logic [NW-1:0]                 shown_r   [SC];
  logic [NW-1:0]                 shown_nxt [SC];
  logic [NW-1:0]                 pending_r [SC];
  logic [NW-1:0]                 pending_nxt [SC];
  logic                          pending_new_r;
  logic                          pending_new_nxt;
  logic [sssd_pkg::POS_W-1:0]    pos_r;
  logic [sssd_pkg::POS_W-1:0]    pos_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [sssd_pkg::PORT_W-1:0]   port_byte_r;
  logic [sssd_pkg::PORT_W-1:0]   port_byte_nxt;

  logic                          out_free;
  logic                          is_tick;
  logic                          fire;
  logic [NW-1:0]                 dec [SC];
  logic [sssd_pkg::POS_W:0]      pos_inc;
  logic [NW-1:0]                 sel;

  assign out_free    = !out_valid_r || out_ready;
  assign is_tick     = (split.kind == sssd_pkg::REQ_TICK);
  assign split_ready = !is_tick || out_free;
  assign fire        = split_valid && split_ready;
  assign pos_inc     = (sssd_pkg::POS_W+1)'(pos_r) + 3'd1;
  assign sel         = 4'b0001 << pos_r;

  // Decimal digits from the remainder and its quotients.
  always_comb begin
    dec[0] = NW'(split.rem - sssd_pkg::REM_W'(split.q10) * 14'd10);
    dec[1] = NW'(split.q10 - sssd_pkg::Q10_W'(split.q100) * 10'd10);
    dec[2] = NW'(split.q100 - sssd_pkg::Q100_W'(split.q1000) * 7'd10);
    dec[3] = split.q1000;
  end

  always_comb begin
    shown_nxt       = shown_r;
    pending_nxt     = pending_r;
    pending_new_nxt = pending_new_r;
    pos_nxt         = pos_r;
    out_valid_nxt   = out_free ? 1'b0 : out_valid_r;
    port_byte_nxt   = port_byte_r;
    if (fire) begin
      unique case (split.kind)
        sssd_pkg::REQ_SET_DIGITS: begin
          for (int k = 0; k < SC; k++) pending_nxt[k] = split.digits[k*NW +: NW];
          pending_new_nxt = 1'b1;
        end
        sssd_pkg::REQ_SET_VALUE: begin
          pending_nxt     = dec;
          pending_new_nxt = 1'b1;
        end
        sssd_pkg::REQ_TICK: begin
          if (pending_new_r) shown_nxt = pending_r;
          pending_new_nxt = 1'b0;
          out_valid_nxt   = 1'b1;
          port_byte_nxt   = {sel, shown_nxt[pos_r]};
          if (pos_inc >= (sssd_pkg::POS_W+1)'(DIGIT_COUNT)) pos_nxt = '0;
          else pos_nxt = sssd_pkg::POS_W'(pos_inc);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SC; k++) begin
        shown_r[k]   <= '0;
        pending_r[k] <= '0;
      end
      pending_new_r <= 1'b0;
      pos_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      shown_r       <= shown_nxt;
      pending_r     <= pending_nxt;
      pending_new_r <= pending_new_nxt;
      pos_r         <= pos_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    port_byte_r <= port_byte_nxt;
  end

  assign out_valid = out_valid_r;
  assign port_byte = port_byte_r;

endmodule

### rtl/core/seven_segment_scan_driver.sv
// Four-digit multiplexed display driver with a double-buffered digit store. Each transfer on
// in_req is one request: set four digit nibbles, set a 16-bit binary value (shown as its four
// low decimal digits, ten-thousands dropped), or a refresh tick. Writes fill the pending
// buffer; a tick first copies fresh pending digits to the shown buffer, then emits one
// port byte on out_res (one-hot display select in bits 7..4, shown digit in bits 3..0) and
// advances the scan, wrapping after DIGIT_COUNT displays. The block takes one request per
// cycle while in_ready is high; a tick's port byte passes through the input register (loaded
// at the transfer edge), the modulo-10000 stage, the reciprocal quotient stage and the result
// register in that order. Writes produce nothing. A tick waits in the quotient stage only
// while the result register holds an untaken byte; the two stages behind it take up to two
// more requests meanwhile, then in_ready drops until the byte is taken.
module seven_segment_scan_driver #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  sssd_in_if.sink    in_req,
  sssd_out_if.source out_res
);

  // Handshake between the conversion pipe and the scan state.
  logic             split_valid;
  logic             split_ready;
  sssd_pkg::split_t split;

  // Register the request, drop ten-thousands, then form decimal quotients.
  sssd_split u_split (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_ready    (in_req.ready),
    .in_kind     (in_req.req_type),
    .in_digits   (in_req.digits_packed),
    .in_value    (in_req.binary_value),
    .split_valid (split_valid),
    .split_ready (split_ready),
    .split       (split)
  );

  // Update the digit buffers and scan position; hold the port byte until taken.
  sssd_scan #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .split_valid (split_valid),
    .split_ready (split_ready),
    .split       (split),
    .out_valid   (out_res.valid),
    .out_ready   (out_res.ready),
    .port_byte   (out_res.port_byte)
  );

endmodule

### rtl/core/sssd_checker.sv
module sssd_checker #(
  parameter int DIGIT_COUNT = 4
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] port_byte
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(port_byte))
    else $error("port byte changed while stalled");

  // Select exactly one display.
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(port_byte[7:4]))
    else $error("display select not one-hot");

  // Never select a display past the scan length.
  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (5'(port_byte[7:4]) < (5'd1 << DIGIT_COUNT)))
    else $error("display select beyond scan length");

  // Come out of reset empty and ready.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not empty after reset");

endmodule

bind seven_segment_scan_driver sssd_checker #(
  .DIGIT_COUNT (DIGIT_COUNT)
) u_sssd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .port_byte (out_res.port_byte)
);
